FILE: hdl/mcr_pkg.sv
// Shared types, constants and helpers for the midpoint circle rasterizer.
`default_nettype none

package mcr_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned STEP_W          = 16;
  localparam int unsigned DV_W            = 32;
  localparam int unsigned RADIUS_W        = 15;
  localparam int unsigned LEN_W           = 16;
  localparam int unsigned SLOTS           = 8;
  localparam int unsigned SLOT_W          = $clog2(SLOTS);
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned D_INIT      = 3;
  localparam int unsigned D_INC_SHORT = 6;
  localparam int unsigned D_INC_DIAG  = 10;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_FILL    = 2'd1,
    PH_OUTLINE = 2'd2
  } phase_e;

  // One iteration's worth of work, handed from the front to the back.
  typedef struct packed {
    logic              is_fill;
    logic [STEP_W-1:0] cx;
    logic [STEP_W-1:0] cy;
    logic [STEP_W-1:0] x;
    logic [STEP_W-1:0] y;
    logic [SLOTS-1:0]  mask;
    logic              done;
  } job_t;

  function automatic logic [DV_W-1:0] prime_dv(input logic [RADIUS_W-1:0] r);
    logic [DV_W-1:0] v;
    v = DV_W'(D_INIT) - DV_W'({r, 1'b0});
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mcr_queue.sv
// Short job queue between the front and the back of the rasterizer.
`default_nettype none

module mcr_queue
  import mcr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  assign head_o  = entries_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: hdl/mcr_front.sv
// Front end: takes requests, runs the midpoint recurrence and queues jobs.
`default_nettype none

module mcr_front
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   req_type_i,
  input  wire logic [COORD_WIDTH-1:0] center_x_i,
  input  wire logic [COORD_WIDTH-1:0] center_y_i,
  input  wire logic [RADIUS_W-1:0]    radius_i,
  input  wire logic                   fill_mode_i,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output job_t                        job_o
);

  phase_e              phase_q, phase_d;
  logic [DV_W-1:0]     dv_q, dv_d;
  logic [STEP_W-1:0]   x_q, x_d;
  logic [STEP_W-1:0]   y_q, y_d;
  logic [STEP_W-1:0]   cx_q, cx_d;
  logic [STEP_W-1:0]   cy_q, cy_d;
  logic [RADIUS_W-1:0] r_q, r_d;

  logic                     accept;
  logic                     d_neg;
  logic signed [STEP_W:0]   xy_diff;
  logic [DV_W-1:0]          inc_short;
  logic [DV_W-1:0]          inc_diag;
  logic [DV_W-1:0]          dv_next;
  logic [STEP_W:0]          x_next;
  logic signed [STEP_W+1:0] y_next;
  logic                     pass_end;
  logic                     x_pos;
  logic                     y_pos;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // One midpoint update. y is kept signed so that a zero radius ends the pass.
  always_comb begin
    d_neg     = dv_q[DV_W-1];
    xy_diff   = $signed({1'b0, x_q}) - $signed({1'b0, y_q});
    inc_short = DV_W'({x_q, 2'b00}) + DV_W'(D_INC_SHORT);
    inc_diag  = {{(DV_W - STEP_W - 3){xy_diff[STEP_W]}}, xy_diff, 2'b00}
                + DV_W'(D_INC_DIAG);
    dv_next   = dv_q + (d_neg ? inc_short : inc_diag);
    x_next    = {1'b0, x_q} + (STEP_W + 1)'(1);
    y_next    = d_neg ? $signed({2'b00, y_q})
                      : $signed({2'b00, y_q}) - $signed((STEP_W + 2)'(1));
    pass_end  = $signed({1'b0, x_next}) > y_next;
    x_pos     = (x_q != '0);
    y_pos     = (y_q != '0);
  end

  always_comb begin
    phase_d = phase_q;
    dv_d    = dv_q;
    x_d     = x_q;
    y_d     = y_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    r_d     = r_q;
    push_o  = 1'b0;

    job_o.is_fill = (phase_q == PH_FILL);
    job_o.cx      = cx_q;
    job_o.cy      = cy_q;
    job_o.x       = x_q;
    job_o.y       = y_q;
    job_o.mask    = (phase_q == PH_FILL)
                    ? {{(SLOTS - 4){1'b0}}, x_pos, x_pos, y_pos, y_pos}
                    : {SLOTS{1'b1}};
    job_o.done    = pass_end;

    if (accept) begin
      if (req_type_i == REQ_START) begin
        cx_d    = STEP_W'(center_x_i);
        cy_d    = STEP_W'(center_y_i);
        r_d     = radius_i;
        phase_d = fill_mode_i ? PH_FILL : PH_OUTLINE;
        dv_d    = prime_dv(radius_i);
        x_d     = '0;
        y_d     = STEP_W'(radius_i);
      end else begin
        case (phase_q)
          PH_FILL: begin
            push_o = x_pos || y_pos;
            dv_d   = dv_next;
            x_d    = x_next[STEP_W-1:0];
            y_d    = y_next[STEP_W-1:0];
            if (pass_end) begin
              phase_d = PH_OUTLINE;
              dv_d    = prime_dv(r_q);
              x_d     = '0;
              y_d     = STEP_W'(r_q);
            end
          end
          PH_OUTLINE: begin
            push_o = 1'b1;
            dv_d   = dv_next;
            x_d    = x_next[STEP_W-1:0];
            y_d    = y_next[STEP_W-1:0];
            if (pass_end) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dv_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      r_q     <= '0;
    end else begin
      phase_q <= phase_d;
      dv_q    <= dv_d;
      x_q     <= x_d;
      y_q     <= y_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      r_q     <= r_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcr_back.sv
// Back end: expands each queued job into pixels or spans, one per cycle while the output is not stalled.
`default_nettype none

module mcr_back
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire job_t                   head_i,
  input  wire logic                   empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        kind_o,
  output logic [COORD_WIDTH-1:0]      pos_x_o,
  output logic [COORD_WIDTH-1:0]      pos_y_o,
  output logic [LEN_W-1:0]            span_len_o,
  output logic                        last_of_step_o,
  output logic                        circle_done_o
);

  logic                   busy_q, busy_d;
  logic [SLOTS-1:0]       rem_q, rem_d;
  logic                   out_valid_q;
  logic                   kind_q;
  logic [COORD_WIDTH-1:0] pos_x_q, pos_y_q;
  logic [LEN_W-1:0]       len_q;
  logic                   last_q, done_q;

  logic [SLOTS-1:0]       act_mask;
  logic [SLOTS-1:0]       rem_next;
  logic [SLOT_W-1:0]      slot;
  logic                   load_ok;
  logic                   issue;
  logic                   last;
  logic [COORD_WIDTH-1:0] cx, cy, xw, yw;
  logic [COORD_WIDTH-1:0] px, py;
  logic [LEN_W-1:0]       len;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign issue   = !empty_i && load_ok;

  // The remaining-slot mask of the job at the queue head picks the next result.
  always_comb begin
    act_mask = busy_q ? rem_q : head_i.mask;
    slot     = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (act_mask[i]) begin
        slot = SLOT_W'(i);
      end
    end
    rem_next = act_mask & ~(SLOTS'(1) << slot);
    last     = (rem_next == '0);
    pop_o    = issue && last;
    busy_d   = busy_q;
    rem_d    = rem_q;
    if (issue) begin
      busy_d = !last;
      rem_d  = rem_next;
    end
  end

  always_comb begin
    cx  = head_i.cx[COORD_WIDTH-1:0];
    cy  = head_i.cy[COORD_WIDTH-1:0];
    xw  = head_i.x[COORD_WIDTH-1:0];
    yw  = head_i.y[COORD_WIDTH-1:0];
    px  = cx;
    py  = cy;
    len = LEN_W'(1);
    if (head_i.is_fill) begin
      case (slot[1:0])
        2'd0: begin
          px  = cx - yw;
          py  = cy + xw;
          len = {head_i.y[LEN_W-2:0], 1'b0};
        end
        2'd1: begin
          px  = cx - yw;
          py  = cy - xw;
          len = {head_i.y[LEN_W-2:0], 1'b0};
        end
        2'd2: begin
          px  = cx - xw;
          py  = cy - yw;
          len = {head_i.x[LEN_W-2:0], 1'b0};
        end
        default: begin
          px  = cx - xw;
          py  = cy + yw;
          len = {head_i.x[LEN_W-2:0], 1'b0};
        end
      endcase
    end else begin
      case (slot)
        3'd0: begin
          px = cx + xw;
          py = cy - yw;
        end
        3'd1: begin
          px = cx - xw;
          py = cy - yw;
        end
        3'd2: begin
          px = cx + yw;
          py = cy - xw;
        end
        3'd3: begin
          px = cx - yw;
          py = cy - xw;
        end
        3'd4: begin
          px = cx + xw;
          py = cy + yw;
        end
        3'd5: begin
          px = cx - xw;
          py = cy + yw;
        end
        3'd6: begin
          px = cx + yw;
          py = cy + xw;
        end
        default: begin
          px = cx - yw;
          py = cy + xw;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      if (load_ok) begin
        out_valid_q <= issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_q  <= head_i.is_fill ? KIND_SPAN : KIND_PIXEL;
      pos_x_q <= px;
      pos_y_q <= py;
      len_q   <= len;
      last_q  <= last;
      done_q  <= last && head_i.done && !head_i.is_fill;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign span_len_o     = len_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;

endmodule

`default_nettype wire

FILE: hdl/midpoint_circle_rasterizer_top.sv
// Top level of the midpoint circle rasterizer.
`default_nettype none

// A start request gives no result. An advance request is taken by the front
// end, which runs one step of the midpoint recurrence and queues the work;
// the back end then emits one result per cycle on the output channel while
// out_stall_i is low: eight pixels for an outline step, two or four spans
// for a fill step (none when the step is empty). The result channel is what
// sets the rate. The two-entry job queue holds the step whose results are
// being emitted plus one more, so the front can take one further advance
// request while earlier results drain; once both entries are taken the
// input stalls, start requests included. The output register takes a new
// result in the same cycle that the previous one is taken.
module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   req_type_i,
  input  wire logic [COORD_WIDTH-1:0] center_x_i,
  input  wire logic [COORD_WIDTH-1:0] center_y_i,
  input  wire logic [RADIUS_W-1:0]    radius_i,
  input  wire logic                   fill_mode_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        kind_o,
  output logic [COORD_WIDTH-1:0]      pos_x_o,
  output logic [COORD_WIDTH-1:0]      pos_y_o,
  output logic [LEN_W-1:0]            span_len_o,
  output logic                        last_of_step_o,
  output logic                        circle_done_o
);

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_head;
  logic q_empty;
  logic q_full;

  mcr_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .fill_mode_i(fill_mode_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (q_push_job)
  );

  mcr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(q_push_job),
    .pop_i     (q_pop),
    .head_o    (q_head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  mcr_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .span_len_o    (span_len_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full && !q_pop))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty))
    else $error("job queue underflow");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && circle_done_o |-> last_of_step_o && (kind_o == KIND_PIXEL))
    else $error("circle end flagged on a result that does not close a step");

  a_pixel_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_PIXEL) |-> span_len_o == LEN_W'(1))
    else $error("pixel result with a length other than one");
`endif

endmodule

`default_nettype wire
